### sv/idt_pkg.sv
// Shared types, codes and constants for the id translation table.
package idt_pkg;

  // Default number of pairs held in each table.
  localparam int DEFAULT_ENTRIES = 64;

  localparam int ID_W = 32;
  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

  // Operation codes.
  localparam logic [2:0] OP_INS_USER  = 3'd0;
  localparam logic [2:0] OP_INS_GROUP = 3'd1;
  localparam logic [2:0] OP_FWD_MAP   = 3'd2;
  localparam logic [2:0] OP_REV_MAP   = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] user_host;
    logic [ID_W-1:0] user_stored;
    logic [ID_W-1:0] group_host;
    logic [ID_W-1:0] group_stored;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] user_result;
    logic [ID_W-1:0] group_result;
    logic            user_hit;
    logic            group_hit;
    logic [1:0]      status;
  } out_item_t;

  // One (host, stored) pair as held in a cell.
  typedef struct packed {
    logic [ID_W-1:0] host;
    logic [ID_W-1:0] stored;
  } id_pair_t;

  // Search wave that travels down a chain of cells.
  typedef struct packed {
    logic            by_host;
    logic            hit;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] result;
  } wave_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } fsm_state_t;

endpackage

### sv/idt_cell.sv
// One cell of a pair table: holds one pair and compares it against the passing search wave.
module idt_cell (
  input  logic              clk,
  input  logic              shift_en,
  input  logic              entry_ok,
  input  idt_pkg::id_pair_t pair_in,
  output idt_pkg::id_pair_t pair_out,
  input  idt_pkg::wave_t    wave_in,
  output idt_pkg::wave_t    wave_out
);
  import idt_pkg::*;

  id_pair_t        pair_r;
  wave_t           wave_r;
  wave_t           wave_nxt;
  logic [ID_W-1:0] cmp_id;
  logic [ID_W-1:0] map_id;

  // The pair moves one cell down on every accepted insert while the table is not full, newest in cell zero.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pair_r <= pair_in;
    end
  end

  // The first match seen from the newest end claims the wave.
  always_comb begin
    cmp_id   = wave_in.by_host ? pair_r.host : pair_r.stored;
    map_id   = wave_in.by_host ? pair_r.stored : pair_r.host;
    wave_nxt = wave_in;
    if (entry_ok && !wave_in.hit && (cmp_id == wave_in.key)) begin
      wave_nxt.hit    = 1'b1;
      wave_nxt.result = map_id;
    end
  end

  // The wave advances by one cell per cycle.
  always_ff @(posedge clk) begin
    wave_r <= wave_nxt;
  end

  assign pair_out = pair_r;
  assign wave_out = wave_r;

endmodule

### sv/idt_chain.sv
// One pair table built as a row of cells with a fill count.
module idt_chain #(
  parameter int ENTRIES = idt_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ins,
  input  logic              clr,
  input  idt_pkg::id_pair_t pair_in,
  input  idt_pkg::wave_t    wave_in,
  output idt_pkg::wave_t    wave_out,
  output logic              full
);
  import idt_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             shift_en;
  id_pair_t         pair_link [ENTRIES];
  wave_t            wave_link [ENTRIES+1];

  assign full     = (count_r == CNT_W'(ENTRIES));
  assign shift_en = ins && !full;

  // Fill count: cells below it hold valid pairs.
  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (shift_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign pair_link[0] = pair_in;
  assign wave_link[0] = wave_in;
  assign wave_out     = wave_link[ENTRIES];

  // The row of cells; the oldest pair falls off the far end only when it is not valid.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i < ENTRIES - 1) begin : g_mid
      idt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .entry_ok (CNT_W'(i) < count_r),
        .pair_in  (pair_link[i]),
        .pair_out (pair_link[i+1]),
        .wave_in  (wave_link[i]),
        .wave_out (wave_link[i+1])
      );
    end else begin : g_last
      idt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .entry_ok (CNT_W'(i) < count_r),
        .pair_in  (pair_link[i]),
        .pair_out (),
        .wave_in  (wave_link[i]),
        .wave_out (wave_link[i+1])
      );
    end
  end

endmodule

### sv/bidirectional_id_translation_table_top.sv
// Top level of the id translation table: control, result register and the two tables.
//
// Input channel in_valid / in_stall / in_data carries one operation: insert a user
// pair, insert a group pair, forward map, reverse map or clear. Every accepted
// transfer gives exactly one transfer on out_valid / out_stall / out_data.
// cfg_wr_en / cfg_wr_data write allow_unmapped, which turns a missed lookup
// into status ok; write it only while the block is idle.
// Each table is a row of TABLE_ENTRIES cells, newest pair in the first cell.
// A lookup sends a search wave down both rows at one cell per cycle; the
// sequencer stays in S_SEARCH while the waves cross the rows, then S_FINISH
// loads the map result into the output register and the block returns to
// idle for the next item. Inserts, clears and unused codes skip S_SEARCH and
// go straight from idle to S_FINISH. One item is in work at a time; the
// output register lets the next item be accepted while a result waits.
// If the receiver stalls, the finished result waits in the block until the
// output register is free. Reset empties both tables, clears allow_unmapped
// and drops any item in work.
module bidirectional_id_translation_table_top #(
  parameter int TABLE_ENTRIES = idt_pkg::DEFAULT_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  idt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output idt_pkg::out_item_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import idt_pkg::*;

  localparam int STEP_W = $clog2(TABLE_ENTRIES);

  fsm_state_t      state_r;
  fsm_state_t      state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  in_item_t        item_r;
  logic            ins_full_r;
  logic            allow_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  out_item_t       out_data_r;
  out_item_t       result;
  logic            accept;
  logic            load;
  logic            is_map_in;
  logic            fwd;
  logic            user_full;
  logic            group_full;
  wave_t           user_wave_in;
  wave_t           group_wave_in;
  wave_t           user_wave_out;
  wave_t           group_wave_out;
  logic [ID_W-1:0] user_key;
  logic [ID_W-1:0] group_key;
  logic            user_miss;
  logic            group_miss;

  assign accept    = in_valid && !in_stall;
  assign is_map_in = (in_data.op == OP_FWD_MAP) || (in_data.op == OP_REV_MAP);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_r <= cfg_wr_data;
    end
  end

  // Latch the item and the full flag of the table it inserts into.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= in_data;
      ins_full_r <= (in_data.op == OP_INS_USER) ? user_full : group_full;
    end
  end

  // Search waves are built from the held item and fed in for the whole search.
  always_comb begin
    fwd       = (item_r.op == OP_FWD_MAP);
    user_key  = fwd ? item_r.user_host : item_r.user_stored;
    group_key = fwd ? item_r.group_host : item_r.group_stored;
    user_wave_in  = '{by_host: fwd, hit: 1'b0, key: user_key, result: user_key};
    group_wave_in = '{by_host: fwd, hit: 1'b0, key: group_key, result: group_key};
  end

  idt_chain #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_user_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (accept && (in_data.op == OP_INS_USER)),
    .clr      (accept && (in_data.op == OP_CLEAR)),
    .pair_in  ('{host: in_data.user_host, stored: in_data.user_stored}),
    .wave_in  (user_wave_in),
    .wave_out (user_wave_out),
    .full     (user_full)
  );

  idt_chain #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_group_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (accept && (in_data.op == OP_INS_GROUP)),
    .clr      (accept && (in_data.op == OP_CLEAR)),
    .pair_in  ('{host: in_data.group_host, stored: in_data.group_stored}),
    .wave_in  (group_wave_in),
    .wave_out (group_wave_out),
    .full     (group_full)
  );

  // Result assembly once the waves have left the last cell.
  always_comb begin
    result     = '0;
    user_miss  = 1'b0;
    group_miss = 1'b0;
    if ((item_r.op == OP_FWD_MAP) || (item_r.op == OP_REV_MAP)) begin
      if (user_key == ID_ALL_ONES) begin
        result.user_result = user_key;
      end else begin
        result.user_hit    = user_wave_out.hit;
        result.user_result = user_wave_out.hit ? user_wave_out.result : user_key;
        user_miss          = !user_wave_out.hit;
      end
      if (group_key == ID_ALL_ONES) begin
        result.group_result = group_key;
      end else begin
        result.group_hit    = group_wave_out.hit;
        result.group_result = group_wave_out.hit ? group_wave_out.result : group_key;
        group_miss          = !group_wave_out.hit;
      end
      if ((user_miss || group_miss) && !allow_r) begin
        result.status = STAT_NOT_FOUND;
      end
    end else if ((item_r.op == OP_INS_USER) || (item_r.op == OP_INS_GROUP)) begin
      result.status = ins_full_r ? STAT_FULL : STAT_OK;
    end
  end

  // Sequencer: idle, search while the waves cross the rows, then hand off the result.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_stall      = 1'b1;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = is_map_in ? S_SEARCH : S_FINISH;
        end
      end
      S_SEARCH: begin
        if (step_r == STEP_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted transfer always moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an accepted transfer");

  // A finished item with a free output register is delivered in the next cycle.
  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FINISH) && (!out_valid_r || !out_stall))
      |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished result was not loaded into the output register");

  // Hits on both sides can never report a failure.
  a_hits_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.user_hit && out_data_r.group_hit)
      |-> (out_data_r.status == STAT_OK))
    else $error("double hit reported a non-ok status");

endmodule
